### rtl/bqgc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bqgc_pkg
// Types, bin edges and coefficient tables of the binned quadratic gain
// correction.
// ---------------------------------------------------------------------------
package bqgc_pkg;

    localparam int NUM_BINS = 14;
    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int SUM_W    = 55;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_RATIO_FLOOR    = 2'd0;
    localparam logic [1:0] REG_RATIO_CEILING  = 2'd1;
    localparam logic [1:0] REG_QUAD_THRESHOLD = 2'd2;

    localparam logic [15:0] RATIO_FLOOR_RST    = 16'd3277;
    localparam logic [15:0] RATIO_CEILING_RST  = 16'd20480;
    localparam logic [15:0] QUAD_THRESHOLD_RST = 16'd4915;

    // Position clamps in Q3.12 (0.02 and 2.49).
    localparam logic [15:0] POS_MIN = 16'd82;
    localparam logic [15:0] POS_MAX = 16'd10199;

    localparam logic [16:0] CORR_ONE = 17'd65536;
    localparam logic [16:0] CORR_MAX = 17'd131071;

    // Half an output LSB at the gap-sum scale of 2^49.
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'h1_0000_0000);

    localparam logic [15:0] BIN_LO [NUM_BINS] = '{
        16'd82,   16'd1024, 16'd1884, 16'd3318, 16'd3727, 16'd4137, 16'd4751,
        16'd6390, 16'd6771, 16'd7373, 16'd8192, 16'd9011, 16'd9421, 16'd9830};
    localparam logic [15:0] BIN_HI [NUM_BINS] = '{
        16'd1024, 16'd1720, 16'd3154, 16'd3727, 16'd4137, 16'd4628, 16'd5898,
        16'd6771, 16'd7373, 16'd8192, 16'd9011, 16'd9421, 16'd9830, 16'd10240};

    // Coefficients scaled by 2^24.
    localparam logic signed [25:0] FLAT_Q24 [NUM_BINS] = '{
        26'sd16835265, 26'sd16838285, 26'sd16826205, 26'sd16818320,
        26'sd16786276, 26'sd16758879, 26'sd16710745, 26'sd16366443,
        26'sd16457123, 26'sd16502841, 26'sd16568038, 26'sd16604092,
        26'sd16626607, 26'sd16627379};
    localparam logic signed [25:0] K0_Q24 [NUM_BINS] = '{
        26'sd16913615, 26'sd16912776, 26'sd16906065, 26'sd16906736,
        26'sd16898347, 26'sd16913615, 26'sd16884087, 26'sd16408939,
        26'sd16498765, 26'sd16478498, 26'sd16535456, 26'sd16601777,
        26'sd16560287, 26'sd16543040};
    localparam logic signed [18:0] K1_Q24 [NUM_BINS] = '{
        -19'sd33480,  -19'sd41674,  -19'sd46600,  -19'sd64593,
        -19'sd83306,  -19'sd132379, -19'sd144874, -19'sd33292,
        19'sd5092,    19'sd128605,  19'sd151433,  19'sd141065,
        19'sd224452,  19'sd250054};
    localparam logic signed [18:0] K2_Q24 [NUM_BINS] = '{
        19'sd0,       19'sd0,       19'sd0,       19'sd0,
        19'sd0,       19'sd0,       19'sd0,       -19'sd29619,
        -19'sd54031,  -19'sd108586, -19'sd121945, -19'sd137741,
        -19'sd156625, -19'sd161088};

    typedef struct packed {
        logic signed [15:0] position;
        logic [15:0]        shape_ratio;
    } bqgc_in_t;

    typedef struct packed {
        logic [16:0]      correction;
        logic [IDX_W-1:0] bin_index;
        logic             in_gap;
    } bqgc_out_t;

    typedef struct packed {
        logic [15:0] ratio_floor;
        logic [15:0] ratio_ceiling;
        logic [15:0] quad_threshold;
    } bqgc_cfg_t;

    // Bin outcome carried down the pipeline; no_bin marks a position in no
    // bin and no gap.
    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic             in_gap;
        logic             no_bin;
    } bqgc_meta_t;

    typedef struct packed {
        bqgc_meta_t  meta;
        logic [15:0] ratio;
        logic        quad;
    } bqgc_loc_t;

    typedef struct packed {
        bqgc_meta_t              meta;
        logic signed [SUM_W-1:0] part_lin;
        logic signed [SUM_W-1:0] part_sq;
    } bqgc_sum_t;

endpackage
`default_nettype wire

### rtl/bqgc_locate.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bqgc_locate
// First stage: clamps the shape ratio and the position magnitude and finds
// the bin or the gap that holds the position.
// ---------------------------------------------------------------------------
module bqgc_locate (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  bqgc_pkg::bqgc_cfg_t  cfg,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  bqgc_pkg::bqgc_in_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output bqgc_pkg::bqgc_loc_t  out_data
);
    import bqgc_pkg::*;

    logic      valid_reg;
    bqgc_loc_t data_reg;
    bqgc_loc_t data_next;

    always_comb begin
        logic [15:0] ratio_c;
        logic [15:0] mag;
        logic        found;
        logic        gap;
        logic [IDX_W-1:0] found_idx;
        logic [IDX_W-1:0] gap_idx;

        ratio_c = in_data.shape_ratio;
        if (ratio_c < cfg.ratio_floor) begin
            ratio_c = cfg.ratio_floor;
        end
        if (ratio_c > cfg.ratio_ceiling) begin
            ratio_c = cfg.ratio_ceiling;
        end

        // The most negative position negates to 0x8000, which is clamped below.
        mag = in_data.position[15] ? 16'(~in_data.position + 16'sd1)
                                   : 16'(in_data.position);
        if (mag < POS_MIN) begin
            mag = POS_MIN;
        end
        if (mag >= BIN_HI[NUM_BINS-1]) begin
            mag = POS_MAX;
        end

        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (mag >= BIN_LO[i] && mag < BIN_HI[i]) begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end

        gap     = 1'b0;
        gap_idx = '0;
        for (int i = 0; i < NUM_BINS - 1; i++) begin
            if (mag >= BIN_HI[i] && mag < BIN_LO[i+1]) begin
                gap     = 1'b1;
                gap_idx = IDX_W'(i);
            end
        end

        data_next.ratio          = ratio_c;
        data_next.quad           = (ratio_c >= cfg.quad_threshold);
        data_next.meta.bin_index = found ? found_idx : (gap ? gap_idx : '0);
        data_next.meta.in_gap    = !found && gap;
        data_next.meta.no_bin    = !found && !gap;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

### rtl/bqgc_poly.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bqgc_poly
// Four stages that evaluate c0 + r*c1 + r*r*c2 for the bin and for its upper
// neighbour: coefficient fetch, first products, second products, partial sums.
// ---------------------------------------------------------------------------
module bqgc_poly (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  bqgc_pkg::bqgc_loc_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output bqgc_pkg::bqgc_sum_t  out_data
);
    import bqgc_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    // Stage 2: coefficients of lane a (the bin) and lane b (the neighbour).
    bqgc_meta_t              meta2_reg;
    logic [15:0]             ratio2_reg;
    logic signed [25:0]      c0a_reg, c0b_reg;
    logic signed [18:0]      c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    logic [IDX_W-1:0]        idx_b;

    // Stage 3: products with r.
    bqgc_meta_t              meta3_reg;
    logic signed [25:0]      c0a3_reg, c0b3_reg;
    logic signed [18:0]      c2a3_reg, c2b3_reg;
    logic signed [35:0]      p1a_reg, p1b_reg;
    logic [31:0]             rr_reg;

    // Stage 4: products with r*r and the constant plus linear terms.
    bqgc_meta_t              meta4_reg;
    logic signed [51:0]      p2a_reg, p2b_reg;
    logic signed [SUM_W-1:0] sa_reg, sb_reg;

    // Stage 5: lanes added, rounding offset folded in.
    bqgc_meta_t              meta5_reg;
    logic signed [SUM_W-1:0] lin_reg, sq_reg;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // Outside a gap lane b repeats lane a, so the sum is always twice a value.
    assign idx_b = (in_data.meta.in_gap && in_data.meta.bin_index != IDX_W'(NUM_BINS - 1))
                 ? in_data.meta.bin_index + IDX_W'(1) : in_data.meta.bin_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy2) begin
            meta2_reg  <= in_data.meta;
            ratio2_reg <= in_data.ratio;
            if (in_data.quad) begin
                c0a_reg <= K0_Q24[in_data.meta.bin_index];
                c0b_reg <= K0_Q24[idx_b];
                c1a_reg <= K1_Q24[in_data.meta.bin_index];
                c1b_reg <= K1_Q24[idx_b];
                c2a_reg <= K2_Q24[in_data.meta.bin_index];
                c2b_reg <= K2_Q24[idx_b];
            end else begin
                c0a_reg <= FLAT_Q24[in_data.meta.bin_index];
                c0b_reg <= FLAT_Q24[idx_b];
                c1a_reg <= '0;
                c1b_reg <= '0;
                c2a_reg <= '0;
                c2b_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            meta3_reg <= meta2_reg;
            c0a3_reg  <= c0a_reg;
            c0b3_reg  <= c0b_reg;
            c2a3_reg  <= c2a_reg;
            c2b3_reg  <= c2b_reg;
            p1a_reg   <= c1a_reg * $signed({1'b0, ratio2_reg});
            p1b_reg   <= c1b_reg * $signed({1'b0, ratio2_reg});
            rr_reg    <= ratio2_reg * ratio2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && rdy4) begin
            meta4_reg <= meta3_reg;
            p2a_reg   <= c2a3_reg * $signed({1'b0, rr_reg});
            p2b_reg   <= c2b3_reg * $signed({1'b0, rr_reg});
            sa_reg    <= (SUM_W'(c0a3_reg) <<< 24) + (SUM_W'(p1a_reg) <<< 12);
            sb_reg    <= (SUM_W'(c0b3_reg) <<< 24) + (SUM_W'(p1b_reg) <<< 12);
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg && rdy5) begin
            meta5_reg <= meta4_reg;
            lin_reg   <= sa_reg + sb_reg + ROUND_HALF;
            sq_reg    <= SUM_W'(p2a_reg) + SUM_W'(p2b_reg);
        end
    end

    assign out_valid         = v5_reg;
    assign out_data.meta     = meta5_reg;
    assign out_data.part_lin = lin_reg;
    assign out_data.part_sq  = sq_reg;

endmodule
`default_nettype wire

### rtl/bqgc_round.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bqgc_round
// Last stage: final sum, half-up rounding to Q1.16 with clipping at zero and
// saturation, and the output register.
// ---------------------------------------------------------------------------
module bqgc_round (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  bqgc_pkg::bqgc_sum_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output bqgc_pkg::bqgc_out_t  out_data
);
    import bqgc_pkg::*;

    logic                  valid_reg;
    bqgc_out_t             data_reg;
    bqgc_out_t             data_next;
    logic signed [SUM_W:0] total;
    logic                  positive;

    // The total already holds the rounding offset, so the unrounded value is
    // above zero exactly when the total is above that offset.
    assign total    = {in_data.part_lin[SUM_W-1], in_data.part_lin}
                    + {in_data.part_sq[SUM_W-1], in_data.part_sq};
    assign positive = total > (SUM_W+1)'(ROUND_HALF);

    always_comb begin
        data_next.bin_index = in_data.meta.bin_index;
        data_next.in_gap    = in_data.meta.in_gap;
        if (in_data.meta.no_bin) begin
            data_next.correction = CORR_ONE;
        end else if (!positive) begin
            data_next.correction = '0;
        end else if (|total[SUM_W-1:50]) begin
            data_next.correction = CORR_MAX;
        end else begin
            data_next.correction = total[49:33];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

### rtl/binned_quadratic_gain_correction.sv
`default_nettype none
// Throughput: one transaction per cycle while the output does not stall; six
// register stages (locate, fetch, two multiplier stages, partial sums, final
// sum and rounding) each hold one. Each stage takes a new item whenever it is
// empty or its successor moves. Reset (aresetn low, synchronous) empties the
// pipeline and loads the register defaults 0.8, 5.0 and 1.2.
// ---------------------------------------------------------------------------
// binned_quadratic_gain_correction
// Position-binned gain correction with a flat or quadratic dependence on the
// shape ratio, averaged across gaps between bins.
// ---------------------------------------------------------------------------
module binned_quadratic_gain_correction (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [1:0]           cfg_index,
    input  wire  [15:0]          cfg_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  bqgc_pkg::bqgc_in_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output bqgc_pkg::bqgc_out_t  m_data
);
    import bqgc_pkg::*;

    bqgc_cfg_t cfg_reg;
    logic      loc_valid, loc_ready;
    bqgc_loc_t loc_data;
    logic      sum_valid, sum_ready;
    bqgc_sum_t sum_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ratio_floor    <= RATIO_FLOOR_RST;
            cfg_reg.ratio_ceiling  <= RATIO_CEILING_RST;
            cfg_reg.quad_threshold <= QUAD_THRESHOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RATIO_FLOOR:    cfg_reg.ratio_floor    <= cfg_data;
                REG_RATIO_CEILING:  cfg_reg.ratio_ceiling  <= cfg_data;
                REG_QUAD_THRESHOLD: cfg_reg.quad_threshold <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    bqgc_locate u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_data  (loc_data)
    );

    bqgc_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_data   (loc_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    bqgc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire

### tb/sv/binned_quadratic_gain_correction_tb.sv
// ---------------------------------------------------------------------------
// binned_quadratic_gain_correction_tb
// Streams cluster items through the gain correction under bursty input and
// a stalling receiver, and compares every result with a built-in model of
// the bin lookup, the flat and quadratic forms and the gap averaging.
// ---------------------------------------------------------------------------
module binned_quadratic_gain_correction_tb;
    import bqgc_pkg::*;

    localparam int  NBINS       = 14;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN       = 20;

    localparam int EDGE_LO [NBINS] = '{
        82, 1024, 1884, 3318, 3727, 4137, 4751, 6390, 6771, 7373, 8192, 9011, 9421, 9830};
    localparam int EDGE_HI [NBINS] = '{
        1024, 1720, 3154, 3727, 4137, 4628, 5898, 6771, 7373, 8192, 9011, 9421, 9830, 10240};

    localparam longint GAIN_FLAT [NBINS] = '{
        16835265, 16838285, 16826205, 16818320, 16786276, 16758879, 16710745,
        16366443, 16457123, 16502841, 16568038, 16604092, 16626607, 16627379};
    localparam longint GAIN_C0 [NBINS] = '{
        16913615, 16912776, 16906065, 16906736, 16898347, 16913615, 16884087,
        16408939, 16498765, 16478498, 16535456, 16601777, 16560287, 16543040};
    localparam longint GAIN_C1 [NBINS] = '{
        -33480, -41674, -46600, -64593, -83306, -132379, -144874,
        -33292, 5092, 128605, 151433, 141065, 224452, 250054};
    localparam longint GAIN_C2 [NBINS] = '{
        0, 0, 0, 0, 0, 0, 0,
        -29619, -54031, -108586, -121945, -137741, -156625, -161088};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_RATIO_FLOOR;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    bqgc_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    bqgc_out_t   m_data;

    // Register copies used by the model.
    logic [15:0] ratio_floor_q    = RATIO_FLOOR_RST;
    logic [15:0] ratio_ceiling_q  = RATIO_CEILING_RST;
    logic [15:0] quad_threshold_q = QUAD_THRESHOLD_RST;

    bqgc_in_t  pending_clusters[$];
    bqgc_out_t expected_corrections[$];

    int mismatches = 0;
    int cycles     = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;

    binned_quadratic_gain_correction i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bin value at a scale of 2^48.
    function automatic longint bin_gain(input int b, input longint r, input bit quad);
        if (!quad) begin
            return GAIN_FLAT[b] * longint'(16777216);
        end
        return GAIN_C0[b] * longint'(16777216) + GAIN_C1[b] * r * longint'(4096)
               + GAIN_C2[b] * r * r;
    endfunction

    // Round half up to Q1.16 from a scale of 2^(48+extra), saturating.
    function automatic logic [16:0] round_gain(input longint v, input int extra);
        longint unsigned u;
        if (v <= 0) begin
            return '0;
        end
        u = v;
        u = (u + (64'd1 << (31 + extra))) >> (32 + extra);
        if (u > 64'd131071) begin
            u = 64'd131071;
        end
        return u[16:0];
    endfunction

    function automatic bqgc_out_t predict_correction(input bqgc_in_t item);
        bqgc_out_t   res;
        logic [15:0] r;
        logic [15:0] mag;
        longint      rl;
        bit          quad;
        int          found;
        r = item.shape_ratio;
        if (r < ratio_floor_q) begin
            r = ratio_floor_q;
        end
        if (r > ratio_ceiling_q) begin
            r = ratio_ceiling_q;
        end
        quad = (r >= quad_threshold_q);
        rl   = longint'(r);
        mag  = item.position[15] ? (~item.position + 16'd1) : item.position;
        if (mag < 16'd82) begin
            mag = 16'd82;
        end
        if (mag >= 16'd10240) begin
            mag = 16'd10199;
        end
        res.correction = CORR_ONE;
        res.bin_index  = '0;
        res.in_gap     = 1'b0;
        found = -1;
        for (int i = 0; i < NBINS; i++) begin
            if (EDGE_LO[i] <= mag && mag < EDGE_HI[i]) begin
                found = i;
            end
        end
        if (found >= 0) begin
            res.correction = round_gain(bin_gain(found, rl, quad), 0);
            res.bin_index  = found[IDX_W-1:0];
        end else begin
            for (int i = 0; i < NBINS - 1; i++) begin
                if (EDGE_HI[i] <= mag && mag < EDGE_LO[i+1]) begin
                    res.correction = round_gain(bin_gain(i, rl, quad)
                                                + bin_gain(i + 1, rl, quad), 1);
                    res.bin_index  = i[IDX_W-1:0];
                    res.in_gap     = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic bqgc_in_t random_cluster();
        bqgc_in_t item;
        int       kind;
        int       pos;
        int       g;
        kind = $urandom_range(0, 9);
        pos  = $urandom_range(0, 10500);
        item.shape_ratio = 16'($urandom_range(0, 24000));
        case (kind)
            0: begin
                pos = $urandom_range(0, 65535);
                item.shape_ratio = 16'($urandom_range(0, 65535));
            end
            7: begin
                // Land between two bins so the averaging path is taken.
                do begin
                    g = $urandom_range(0, NBINS - 2);
                end while (EDGE_HI[g] >= EDGE_LO[g+1]);
                pos = $urandom_range(EDGE_HI[g], EDGE_LO[g+1] - 1);
            end
            8: begin
                g   = $urandom_range(0, NBINS - 1);
                pos = ($urandom_range(0, 1) ? EDGE_HI[g] : EDGE_LO[g]) + $urandom_range(0, 4) - 2;
            end
            9: begin
                item.shape_ratio = quad_threshold_q + 16'($urandom_range(0, 6)) - 16'd3;
            end
            default: begin
            end
        endcase
        if (kind != 0 && $urandom_range(0, 1)) begin
            pos = -pos;
        end
        item.position = 16'(pos);
        return item;
    endfunction

    task automatic add_cluster(input int pos, input int ratio);
        bqgc_in_t item;
        item.position    = 16'(pos);
        item.shape_ratio = 16'(ratio);
        pending_clusters.push_back(item);
    endtask

    task automatic add_random(input int n);
        repeat (n) pending_clusters.push_back(random_cluster());
    endtask

    // Lets the stream drain so that registers change only while idle.
    task automatic wait_idle();
        while (pending_clusters.size() != 0 || expected_corrections.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RATIO_FLOOR:    ratio_floor_q    = val;
            REG_RATIO_CEILING:  ratio_ceiling_q  = val;
            REG_QUAD_THRESHOLD: quad_threshold_q = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] thr);
        write_reg(REG_RATIO_FLOOR, lo);
        write_reg(REG_RATIO_CEILING, hi);
        write_reg(REG_QUAD_THRESHOLD, thr);
    endtask

    // Input driver: bursts of transactions separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_corrections.push_back(predict_correction(s_data));
            end
            if (!(s_valid && !s_ready)) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left > 0 && pending_clusters.size() > 0) begin
                    s_data     <= pending_clusters.pop_front();
                    s_valid    <= 1'b1;
                    burst_left = burst_left - 1;
                end else begin
                    s_valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0) begin
                        gap_left = gap_left - 1;
                    end
                end
            end
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge aclk) begin
        bqgc_out_t want;
        if (cycles % 150 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 9) != 0);
            default: m_ready <= ((cycles % 7) >= 3);
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (expected_corrections.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("unexpected result: correction %0d bin %0d gap %0d",
                             m_data.correction, m_data.bin_index, m_data.in_gap);
                end
            end else begin
                want = expected_corrections.pop_front();
                if (m_data.correction !== want.correction || m_data.bin_index !== want.bin_index
                    || m_data.in_gap !== want.in_gap) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected correction %0d bin %0d gap %0d, got %0d %0d %0d",
                                 want.correction, want.bin_index, want.in_gap,
                                 m_data.correction, m_data.bin_index, m_data.in_gap);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Default registers: field extremes, clamp edges, bin edges and gaps.
        add_cluster(0, 0);
        add_cluster(32767, 65535);
        add_cluster(-32768, 4915);
        add_cluster(-1, 4914);
        add_cluster(81, 3277);
        add_cluster(82, 3276);
        add_cluster(10239, 20480);
        add_cluster(10240, 20481);
        add_cluster(10199, 12000);
        add_cluster(1800, 5000);
        add_cluster(-1800, 2000);
        add_cluster(3200, 6000);
        add_cluster(-4700, 6000);
        add_cluster(6000, 8000);
        add_cluster(-6000, 1000);
        add_cluster(1024, 4915);
        add_cluster(1719, 4915);
        add_cluster(1720, 4915);
        add_cluster(1884, 4915);
        add_cluster(-9830, 65535);
        add_random(200);
        wait_idle();

        // Full ratio range, always quadratic: large ratios drive values negative.
        set_window(16'd0, 16'd65535, 16'd0);
        add_cluster(9900, 65535);
        add_cluster(-10000, 0);
        add_cluster(6000, 65535);
        add_cluster(-32768, 32768);
        add_random(200);
        wait_idle();

        // Floor above ceiling pins the ratio to the ceiling.
        set_window(16'd65535, 16'd0, 16'd0);
        add_cluster(5000, 0);
        add_cluster(-5000, 65535);
        add_random(150);
        wait_idle();

        // Threshold at the top: flat form everywhere but the largest ratio.
        set_window(16'd0, 16'd65535, 16'd65535);
        add_cluster(9000, 65535);
        add_random(150);
        wait_idle();

        repeat (3) begin
            set_window(16'($urandom_range(0, 8000)), 16'($urandom_range(2000, 65535)),
                       16'($urandom_range(0, 24000)));
            add_random(200);
            wait_idle();
        end

        set_window(RATIO_FLOOR_RST, RATIO_CEILING_RST, QUAD_THRESHOLD_RST);
        add_random(100);
        wait_idle();

        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && expected_corrections.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### binned_quadratic_gain_correction.f
rtl/bqgc_pkg.sv
rtl/bqgc_locate.sv
rtl/bqgc_poly.sv
rtl/bqgc_round.sv
rtl/binned_quadratic_gain_correction.sv
tb/sv/binned_quadratic_gain_correction_tb.sv
